>>> rtl/sqd_pkg.sv
// Shared field widths, codes and types for the shortest-queue dispatch block.
`timescale 1ns / 1ps
package sqd_pkg;

	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 3;
	localparam int STATUS_W = 2;
	localparam int ACTIVE_W = 4;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

>>> rtl/sqd_select.sv
// Compare tree that picks the shortest or longest enabled queue, lowest index on a tie.
`timescale 1ns / 1ps
module sqd_select #(
	parameter int NUM_QUEUES = 8,
	parameter int CW = 6,
	parameter int QW = 3
) (
	input  logic [NUM_QUEUES-1:0][CW-1:0] counts,
	input  logic [NUM_QUEUES-1:0]         enable,
	input  logic                          longest,
	output logic [QW-1:0]                 best_index,
	output logic [CW-1:0]                 best_count
);
	localparam int LV = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int NL = 2 ** LV;

	logic [CW-1:0] val [LV+1][NL];
	logic [QW-1:0] idx [LV+1][NL];
	logic          ok  [LV+1][NL];

	always_comb begin
		logic take_right;
		for (int l = 0; l <= LV; l++) begin
			for (int i = 0; i < NL; i++) begin
				val[l][i] = '0;
				idx[l][i] = '0;
				ok[l][i]  = 1'b0;
			end
		end
		for (int i = 0; i < NUM_QUEUES; i++) begin
			val[0][i] = counts[i];
			idx[0][i] = QW'(i);
			ok[0][i]  = enable[i];
		end
		for (int l = 0; l < LV; l++) begin
			for (int j = 0; j < (NL >> (l + 1)); j++) begin
				take_right = ok[l][2*j+1] && (!ok[l][2*j] ||
					(longest ? (val[l][2*j+1] > val[l][2*j])
					         : (val[l][2*j+1] < val[l][2*j])));
				val[l+1][j] = take_right ? val[l][2*j+1] : val[l][2*j];
				idx[l+1][j] = take_right ? idx[l][2*j+1] : idx[l][2*j];
				ok[l+1][j]  = ok[l][2*j] | ok[l][2*j+1];
			end
		end
	end

	assign best_index = idx[LV][0];
	assign best_count = val[LV][0];

endmodule

>>> rtl/sqd_ptr_ram.sv
// Head and tail pointer memory, one entry per queue, reading as zero until first written.
`timescale 1ns / 1ps
module sqd_ptr_ram #(
	parameter int NUM_QUEUES = 8,
	parameter int PW = 5,
	parameter int QW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [QW-1:0] rd_addr,
	output logic [PW-1:0] rd_head,
	output logic [PW-1:0] rd_tail,
	input  logic          wr_en,
	input  logic [QW-1:0] wr_addr,
	input  logic [PW-1:0] wr_head,
	input  logic [PW-1:0] wr_tail
);
	logic [2*PW-1:0]       mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] written_q;
	logic [2*PW-1:0]       rd_data_q;
	logic                  rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_head, wr_tail};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_head = rd_written_q ? rd_data_q[2*PW-1:PW] : '0;
	assign rd_tail = rd_written_q ? rd_data_q[PW-1:0]    : '0;

endmodule

>>> rtl/sqd_byte_ram.sv
// Byte storage shared by all queues, one write and one registered read port.
`timescale 1ns / 1ps
module sqd_byte_ram
	import sqd_pkg::*;
#(
	parameter int ENTRIES = 256,
	parameter int AW = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);
	logic [BYTE_W-1:0] mem [ENTRIES];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/shortest_queue_dispatch_fifos.sv
// Top level of the shortest-queue dispatch block over a bank of byte queues.
// Items arrive on the s_axis channel: tuser selects enqueue (0) or dequeue (1),
// tdata carries the byte to enqueue. An enqueue goes to the active queue with
// the fewest entries, a dequeue takes from the one with the most, lowest index
// on a tie. Every item gives one result on m_axis: queue index, status
// (done, full or empty) and the byte removed on a successful dequeue.
// The cfg channel sets how many queues take part; it is always ready and
// should only be written while no item is in flight.
// An item is accepted in one cycle, its pointers are read from the pointer
// memory and updated in the next, and its result then waits in the done state
// until the output register is free to take it. A new item is accepted only
// while idle or as the previous result enters the output register.
// Reset empties every queue and restores all active queues; no clearing pass
// is needed. While the receiver stalls, one result waits in the output
// register and the next item is carried through until its own result is due.
`timescale 1ns / 1ps
module shortest_queue_dispatch_fifos
	import sqd_pkg::*;
#(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // data_in
	input  logic [0:0]          s_axis_tuser,  // cmd
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,  // queue_index, status, data_out
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ACTIVE_W-1:0] cfg_data       // active_queues
);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW = $clog2(ENTRIES);
	localparam int OUT_PAD = 16 - INDEX_W - STATUS_W - BYTE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACCESS,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [ACTIVE_W-1:0]           active_q;
	logic [NUM_QUEUES-1:0][CW-1:0] count_q;
	logic [NUM_QUEUES-1:0]         enable;

	logic          cmd_s1;
	logic [7:0]    data_s1;
	logic [QW-1:0] q_s1;
	logic          fail_s1;

	logic [QW-1:0] q_s2;
	status_t       status_s2;
	logic          deq_ok_s2;

	logic [QW-1:0] sel_index;
	logic [CW-1:0] sel_count;
	logic          take;
	logic          out_free;
	logic          sel_fail;

	logic [PW-1:0] rd_head;
	logic [PW-1:0] rd_tail;
	logic [PW-1:0] next_head;
	logic [PW-1:0] next_tail;
	logic          access_go;
	logic          enq_go;
	logic          deq_go;
	logic [AW-1:0] byte_addr;
	logic [7:0]    byte_rd;
	logic [7:0]    result_byte;

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			enable[i] = (i == 0) || (32'(i) < 32'(active_q));
		end
	end

	sqd_select #(
		.NUM_QUEUES(NUM_QUEUES),
		.CW(CW),
		.QW(QW)
	) u_select (
		.counts(count_q),
		.enable(enable),
		.longest(s_axis_tuser[0] == CMD_DEQ),
		.best_index(sel_index),
		.best_count(sel_count)
	);

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
	assign take          = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign sel_fail      = (s_axis_tuser[0] == CMD_DEQ) ? (sel_count == '0)
	                                                    : (sel_count >= CW'(QUEUE_DEPTH));

	assign access_go = (state_q == S_ACCESS) && !fail_s1;
	assign enq_go    = access_go && (cmd_s1 == CMD_ENQ);
	assign deq_go    = access_go && (cmd_s1 == CMD_DEQ);
	assign next_head = deq_go ? ((rd_head == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_head + 1'b1)
	                          : rd_head;
	assign next_tail = enq_go ? ((rd_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_tail + 1'b1)
	                          : rd_tail;
	assign byte_addr = AW'(AW'(q_s1) * AW'(QUEUE_DEPTH)
	                       + AW'(cmd_s1 == CMD_DEQ ? rd_head : rd_tail));

	sqd_ptr_ram #(
		.NUM_QUEUES(NUM_QUEUES),
		.PW(PW),
		.QW(QW)
	) u_ptr_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(take),
		.rd_addr(sel_index),
		.rd_head(rd_head),
		.rd_tail(rd_tail),
		.wr_en(access_go),
		.wr_addr(q_s1),
		.wr_head(next_head),
		.wr_tail(next_tail)
	);

	sqd_byte_ram #(
		.ENTRIES(ENTRIES),
		.AW(AW)
	) u_byte_ram (
		.clk(clk),
		.wr_en(enq_go),
		.wr_addr(byte_addr),
		.wr_data(data_s1),
		.rd_en(deq_go),
		.rd_addr(byte_addr),
		.rd_data(byte_rd)
	);

	assign result_byte = deq_ok_s2 ? byte_rd : '0;

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= s_axis_tuser[0];
			data_s1 <= s_axis_tdata;
			q_s1    <= sel_index;
			fail_s1 <= sel_fail;
		end
		if (state_q == S_ACCESS) begin
			q_s2      <= q_s1;
			deq_ok_s2 <= deq_go;
			if (!fail_s1) begin
				status_s2 <= ST_DONE;
			end else if (cmd_s1 == CMD_DEQ) begin
				status_s2 <= ST_EMPTY;
			end else begin
				status_s2 <= ST_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			active_q      <= ACTIVE_RESET;
			count_q       <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			if ((state_q == S_DONE) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_ACCESS;
					end
				end
				S_ACCESS: begin
					if (enq_go) begin
						count_q[q_s1] <= count_q[q_s1] + 1'b1;
					end else if (deq_go) begin
						count_q[q_s1] <= count_q[q_s1] - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_axis_tdata  <= {{OUT_PAD{1'b0}}, result_byte, status_s2,
						                  INDEX_W'(q_s2)};
						state_q       <= take ? S_ACCESS : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> bench/shortest_queue_dispatch_fifos_test.sv
// Self-checking testbench for the shortest-queue dispatch block with a queue-bank predictor.
`timescale 1ns / 1ps
module shortest_queue_dispatch_fifos_test;
	import sqd_pkg::*;

	localparam int NQ          = 8;
	localparam int DEPTH       = 32;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [INDEX_W-1:0] queue_index;
		status_t            status;
		logic [BYTE_W-1:0]  data_out;
	} dispatch_result_t;

	class dispatch_predictor;
		int unsigned      fill[NQ];
		int unsigned      rd_slot[NQ];
		int unsigned      wr_slot[NQ];
		logic [7:0]       bytes[NQ][DEPTH];
		int unsigned      live;
		dispatch_result_t pending_dispatches[$];
		int unsigned      mismatches;

		function new();
			live = ACTIVE_RESET;
			mismatches = 0;
		endfunction

		function void set_active(logic [ACTIVE_W-1:0] value);
			if (value == 0)
				live = 1;
			else if (value > NQ)
				live = NQ;
			else
				live = value;
		endfunction

		function int unsigned pick(bit longest);
			int unsigned best;
			best = 0;
			for (int unsigned q = 1; q < live; q++) begin
				if (longest ? (fill[q] > fill[best]) : (fill[q] < fill[best]))
					best = q;
			end
			return best;
		endfunction

		function void accept_item(logic cmd, logic [7:0] data);
			dispatch_result_t r;
			int unsigned q;
			r.data_out = '0;
			r.status = ST_DONE;
			if (cmd == CMD_ENQ) begin
				q = pick(1'b0);
				if (fill[q] >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					bytes[q][wr_slot[q]] = data;
					wr_slot[q] = (wr_slot[q] + 1) % DEPTH;
					fill[q]++;
				end
			end else begin
				q = pick(1'b1);
				if (fill[q] == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data_out = bytes[q][rd_slot[q]];
					rd_slot[q] = (rd_slot[q] + 1) % DEPTH;
					fill[q]--;
				end
			end
			r.queue_index = q[INDEX_W-1:0];
			pending_dispatches.push_back(r);
		endfunction

		function void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0d, got %0d", what, exp_v, got_v);
		endfunction

		function void check_dispatch(logic [15:0] word);
			dispatch_result_t r;
			if (pending_dispatches.size() == 0) begin
				note_mismatch("result count (unexpected transfer)", 0, 1);
				return;
			end
			r = pending_dispatches.pop_front();
			if (word[2:0] !== r.queue_index)
				note_mismatch("queue_index", r.queue_index, word[2:0]);
			if (word[4:3] !== r.status)
				note_mismatch("status", r.status, word[4:3]);
			if (word[12:5] !== r.data_out)
				note_mismatch("data_out", r.data_out, word[12:5]);
		endfunction

		function int unsigned outstanding();
			return pending_dispatches.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;  // data_in
	logic [0:0]          s_axis_tuser;  // cmd
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [15:0]         m_axis_tdata;  // queue_index, status, data_out
	logic                cfg_valid;
	logic                cfg_ready;
	logic [ACTIVE_W-1:0] cfg_data;      // active_queues

	dispatch_predictor predictor;
	bit                tx_idle_on;
	bit                rx_idle_on;
	int unsigned       rx_stall_left;
	int unsigned       quiet_cycles;

	shortest_queue_dispatch_fifos #(
		.NUM_QUEUES (NQ),
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// The receiver checks each result transfer and, while rx_idle_on is set, stalls in random bursts.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			predictor.check_dispatch(m_axis_tdata);
		if (rx_idle_on && rx_stall_left > 0) begin
			rx_stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall_left = $urandom_range(1, 10) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("shortest_queue_dispatch_fifos regression: fail");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] data);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predictor.accept_item(cmd, data);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (predictor.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active(input logic [ACTIVE_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		predictor.set_active(value);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_items(input int unsigned count, input int unsigned enq_pct);
		for (int unsigned i = 0; i < count; i++)
			send_item(($urandom_range(1, 100) <= enq_pct) ? CMD_ENQ : CMD_DEQ,
				8'($urandom_range(0, 255)));
	endtask

	logic [ACTIVE_W-1:0] active_plan[12] = '{4'd15, 4'd1, 4'd3, 4'd8, 4'd9, 4'd2,
		4'd5, 4'd12, 4'd6, 4'd4, 4'd7, 4'd8};

	initial begin
		predictor = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_ENQ;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_stall_left = 0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state, all eight queues: empty dequeue, extreme bytes, spread and collect.
		send_item(CMD_DEQ, 8'h00);
		send_item(CMD_ENQ, 8'h00);
		send_item(CMD_ENQ, 8'hFF);
		send_item(CMD_ENQ, 8'hA5);
		send_item(CMD_ENQ, 8'h5A);
		send_item(CMD_ENQ, 8'h01);
		for (int i = 0; i < 6; i++)
			send_item(CMD_DEQ, 8'hFF);

		// A setting of zero leaves queue zero alone: fill it past full, then empty it.
		write_active('0);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int i = 0; i < DEPTH + 2; i++)
			send_item(CMD_ENQ, 8'($urandom_range(0, 255)));
		for (int i = 0; i < DEPTH + 2; i++)
			send_item(CMD_DEQ, 8'($urandom_range(0, 255)));

		foreach (active_plan[p]) begin
			write_active(active_plan[p]);
			tx_idle_on = (p != 11) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (p != 11) && ($urandom_range(0, 3) != 0);
			random_items(28, $urandom_range(25, 85));
		end

		drain();
		repeat (8) @(posedge clk);
		if (predictor.mismatches == 0 && predictor.outstanding() == 0)
			$display("shortest_queue_dispatch_fifos regression: pass");
		else
			$display("shortest_queue_dispatch_fifos regression: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/sqd_pkg.sv
rtl/sqd_select.sv
rtl/sqd_ptr_ram.sv
rtl/sqd_byte_ram.sv
rtl/shortest_queue_dispatch_fifos.sv
bench/shortest_queue_dispatch_fifos_test.sv
